// ----- design/yaw_pitch_look_direction_defines.svh -----
// ---------------------------------------------------------------------------
// yaw_pitch_look_direction assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef YAW_PITCH_LOOK_DIRECTION_DEFINES_SVH
`define YAW_PITCH_LOOK_DIRECTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define YPLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define YPLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ypld_pkg.sv -----
// ---------------------------------------------------------------------------
// ypld_pkg
// Types and fixed constants of the look direction block: field widths,
// CORDIC seed and arctangent table, sequencer states.
// ---------------------------------------------------------------------------
package ypld_pkg;

  // Field widths of the stream items and the gain register
  localparam int DELTA_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int DIR_W     = 16;
  localparam int HEAD_W    = 16;
  localparam int ELEV_W    = 15;
  localparam int IN_W      = 2 * DELTA_W;
  localparam int OUT_W     = 80;

  // Rotation unit: angles of 2^32 units per turn, results in Q2.30
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [33:0] CORDIC_START = 34'sd652032875;

  // Sine and cosine of one angle
  typedef struct packed {
    logic signed [CORDIC_W-1:0] cos_v;
    logic signed [CORDIC_W-1:0] sin_v;
  } ypld_sincos_t;

  // Item sequencer
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STEP   = 5'b00010,
    ST_ROTATE = 5'b00100,
    ST_PROD   = 5'b01000,
    ST_DONE   = 5'b10000
  } ypld_state_t;

  // Arctangent of 2^-i, 2^32 units per turn
  function automatic logic [CORDIC_W-1:0] ypld_arc(input logic [ITER_W-1:0] i);
    logic [CORDIC_W-1:0] v;
    begin
      case (i)
        5'd0:    v = 32'd536870912;
        5'd1:    v = 32'd316933406;
        5'd2:    v = 32'd167458907;
        5'd3:    v = 32'd85004756;
        5'd4:    v = 32'd42667331;
        5'd5:    v = 32'd21354465;
        5'd6:    v = 32'd10679838;
        5'd7:    v = 32'd5340245;
        5'd8:    v = 32'd2670163;
        5'd9:    v = 32'd1335087;
        5'd10:   v = 32'd667544;
        5'd11:   v = 32'd333772;
        5'd12:   v = 32'd166886;
        5'd13:   v = 32'd83443;
        5'd14:   v = 32'd41722;
        5'd15:   v = 32'd20861;
        5'd16:   v = 32'd10430;
        5'd17:   v = 32'd5215;
        5'd18:   v = 32'd2608;
        5'd19:   v = 32'd1304;
        5'd20:   v = 32'd652;
        5'd21:   v = 32'd326;
        5'd22:   v = 32'd163;
        5'd23:   v = 32'd81;
        5'd24:   v = 32'd41;
        5'd25:   v = 32'd20;
        5'd26:   v = 32'd10;
        5'd27:   v = 32'd5;
        5'd28:   v = 32'd3;
        5'd29:   v = 32'd1;
        5'd30:   v = 32'd1;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- design/ypld_serial_mul.sv -----
// ---------------------------------------------------------------------------
// ypld_serial_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first,
// with the sign bit weighted negative. Product is exact and held after done.
// ---------------------------------------------------------------------------
module ypld_serial_mul #(
  parameter int A_W = 17,
  parameter int B_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic                     done,
  output logic signed [A_W+B_W-1:0] product
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W);

  logic signed [P_W-1:0] acc;
  logic signed [P_W-1:0] mcand;
  logic [B_W-1:0]        mplier;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  last;
  logic signed [P_W-1:0] addend;

  assign last = (cnt == CNT_W'(B_W - 1));

  // Select the partial product for the current multiplier bit
  always_comb begin
    if (!mplier[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Shift and accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= P_W'(a);
      mplier <= b;
    end else if (busy) begin
      acc    <= acc + addend;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;

endmodule

// ----- design/ypld_cordic.sv -----
// ---------------------------------------------------------------------------
// ypld_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, with a
// half-turn fold for angles in the left half plane.
// ---------------------------------------------------------------------------
module ypld_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ypld_pkg::CORDIC_W-1:0] angle,
  output logic                          done,
  output ypld_pkg::ypld_sincos_t        result
);

  import ypld_pkg::*;

  logic signed [33:0]       x;
  logic signed [33:0]       y;
  logic signed [32:0]       z;
  logic                     flip;
  logic [ITER_W-1:0]        iter;
  logic                     busy;
  logic                     last;
  logic [CORDIC_W-1:0]      quarter_sum;
  logic [CORDIC_W-1:0]      folded;
  logic signed [33:0]       dx;
  logic signed [33:0]       dy;
  logic signed [32:0]       arc;
  logic signed [33:0]       x_neg;
  logic signed [33:0]       y_neg;

  assign last = (iter == ITER_W'(CORDIC_STEPS - 1));

  // Fold angles in [90, 270) degrees by half a turn
  assign quarter_sum = angle + 32'h4000_0000;
  assign folded      = quarter_sum[CORDIC_W-1] ? (angle + 32'h8000_0000) : angle;

  // Floor shifts and table angle of this iteration
  assign dx  = y >>> iter;
  assign dy  = x >>> iter;
  assign arc = {1'b0, ypld_arc(iter)};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
        end
        iter <= iter + 1'b1;
      end
    end
  end

  // Micro-rotation datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_START;
      y    <= '0;
      z    <= {folded[CORDIC_W-1], folded};
      flip <= quarter_sum[CORDIC_W-1];
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - arc;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + arc;
      end
    end
  end

  // Undo the fold by negating both results
  assign x_neg = -x;
  assign y_neg = -y;
  assign result.cos_v = flip ? x_neg[CORDIC_W-1:0] : x[CORDIC_W-1:0];
  assign result.sin_v = flip ? y_neg[CORDIC_W-1:0] : y[CORDIC_W-1:0];

endmodule

// ----- design/yaw_pitch_look_direction.sv -----
// ---------------------------------------------------------------------------
// yaw_pitch_look_direction
// First-person camera: mouse deltas in, heading/elevation and unit look
// vector out.
// ---------------------------------------------------------------------------
// Each accepted delta pair scales by turn_gain (Q8.8 angle units per count),
// adds to the heading (wrapping over one turn) and subtracts from the
// elevation (clamped to +-89 degrees), then yields one result holding the
// look vector (cos p sin h, sin p, -cos p cos h) in Q1.DIR_FRAC_BITS and the
// updated angles. One item occupies the block from acceptance until the next
// can be accepted: it passes the bit-serial gain multipliers, then the
// iterative CORDIC units (heading and elevation run side by side), then the
// bit-serial products and the hand-over to the output register. The
// result sits in an output register, so the next item is taken while it
// waits downstream.
// ---------------------------------------------------------------------------
module yaw_pitch_look_direction #(
  parameter int ANGLE_BITS    = 16,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  // Gain register write
  input  logic                        cfg_we,
  input  logic [ypld_pkg::GAIN_W-1:0] cfg_wdata,
  // Input stream; tdata: delta_x[15:0], delta_y[31:16]
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ypld_pkg::IN_W-1:0]   s_axis_tdata,
  // Output stream; tdata: look_x[15:0], look_y[31:16], look_z[47:32],
  // heading[63:48], elevation[78:64], zero[79]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ypld_pkg::OUT_W-1:0]  m_axis_tdata
);

  import ypld_pkg::*;

  `include "yaw_pitch_look_direction_defines.svh"

  localparam int STEP_PROD_W = GAIN_W + 1 + DELTA_W;
  localparam int STEP_W      = STEP_PROD_W - GAIN_FRAC;
  localparam int EW          = ANGLE_BITS - 1;
  localparam int P_W         = ((EW > STEP_W) ? EW : STEP_W) + 1;
  localparam int PROD_W      = 2 * CORDIC_W;
  localparam int SH_P        = 60 - DIR_FRAC_BITS;
  localparam int SH_S        = 30 - DIR_FRAC_BITS;
  localparam longint PITCH_LIMIT = ((longint'(89) <<< ANGLE_BITS) + 180) / 360;
  localparam logic signed [P_W-1:0] P_MAX    = P_W'(PITCH_LIMIT);
  localparam logic signed [P_W-1:0] P_MIN    = -P_MAX;
  localparam logic signed [EW-1:0]  ELEV_MAX = EW'(PITCH_LIMIT);
  localparam logic signed [EW-1:0]  ELEV_MIN = -ELEV_MAX;

  // Round half up to DIR_FRAC_BITS, clamp to +-1.0, keep the field width
  function automatic logic [DIR_W-1:0] dir_round(input logic signed [63:0] v,
                                                 input int sh);
    logic signed [63:0] r;
    logic signed [63:0] lim;
    begin
      lim = 64'sd1 <<< DIR_FRAC_BITS;
      r   = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > lim) begin
        r = lim;
      end
      if (r < -lim) begin
        r = -lim;
      end
      return r[DIR_W-1:0];
    end
  endfunction

  logic [GAIN_W-1:0]              turn_gain;
  logic [ANGLE_BITS-1:0]          heading_angle;
  logic signed [EW-1:0]           elevation_angle;
  ypld_state_t                    state;
  ypld_state_t                    state_next;

  logic                           in_accept;
  logic signed [GAIN_W:0]         gain_s;
  logic signed [STEP_PROD_W-1:0]  prod_h;
  logic signed [STEP_PROD_W-1:0]  prod_p;
  logic                           done_h;
  logic                           done_p;
  logic                           step_done;
  logic signed [STEP_W-1:0]       step_h;
  logic signed [STEP_W-1:0]       step_p;
  logic [ANGLE_BITS-1:0]          heading_next;
  logic signed [P_W-1:0]          p_diff;
  logic signed [P_W-1:0]          p_clamp;
  logic [CORDIC_W-1:0]            head_turn;
  logic [CORDIC_W-1:0]            pitch_turn;

  logic                           rot_done_h;
  logic                           rot_done_p;
  logic                           rot_done;
  ypld_sincos_t                   sc_h;
  ypld_sincos_t                   sc_p;

  logic signed [PROD_W-1:0]       prod_x;
  logic signed [PROD_W-1:0]       prod_z;
  logic                           done_x;
  logic                           done_z;
  logic                           prod_done;

  logic                           out_load;
  logic [DIR_W-1:0]               look_x;
  logic [DIR_W-1:0]               look_y;
  logic [DIR_W-1:0]               look_z;
  logic [31:0]                    head_ext;
  logic signed [P_W-1:0]          elev_ext;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign gain_s        = {1'b0, turn_gain};

  // Hold the gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain <= GAIN_W'(256);
    end else if (cfg_we) begin
      turn_gain <= cfg_wdata;
    end
  end

  // Scale the deltas bit-serially
  ypld_serial_mul #(.A_W(GAIN_W + 1), .B_W(DELTA_W)) u_mul_h (
    .clk     (clk),
    .rst     (rst),
    .start   (in_accept),
    .a       (gain_s),
    .b       (s_axis_tdata[DELTA_W-1:0]),
    .done    (done_h),
    .product (prod_h)
  );

  ypld_serial_mul #(.A_W(GAIN_W + 1), .B_W(DELTA_W)) u_mul_p (
    .clk     (clk),
    .rst     (rst),
    .start   (in_accept),
    .a       (gain_s),
    .b       (s_axis_tdata[IN_W-1:DELTA_W]),
    .done    (done_p),
    .product (prod_p)
  );

  assign step_done = done_h && done_p;

  // Floor the Q8.8 steps, wrap the heading and clamp the elevation
  assign step_h       = prod_h[STEP_PROD_W-1:GAIN_FRAC];
  assign step_p       = prod_p[STEP_PROD_W-1:GAIN_FRAC];
  assign heading_next = heading_angle + step_h[ANGLE_BITS-1:0];
  assign p_diff       = P_W'(elevation_angle) - P_W'(step_p);

  always_comb begin
    if (p_diff > P_MAX) begin
      p_clamp = P_MAX;
    end else if (p_diff < P_MIN) begin
      p_clamp = P_MIN;
    end else begin
      p_clamp = p_diff;
    end
  end

  assign head_turn  = {heading_next, {(CORDIC_W - ANGLE_BITS){1'b0}}};
  assign pitch_turn = {p_clamp[ANGLE_BITS-1:0], {(CORDIC_W - ANGLE_BITS){1'b0}}};

  // Update the angle state once the steps are known
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_angle   <= '0;
      elevation_angle <= '0;
    end else if ((state == ST_STEP) && step_done) begin
      heading_angle   <= heading_next;
      elevation_angle <= p_clamp[EW-1:0];
    end
  end

  // Sine and cosine of both angles
  ypld_cordic u_rot_h (
    .clk    (clk),
    .rst    (rst),
    .start  ((state == ST_STEP) && step_done),
    .angle  (head_turn),
    .done   (rot_done_h),
    .result (sc_h)
  );

  ypld_cordic u_rot_p (
    .clk    (clk),
    .rst    (rst),
    .start  ((state == ST_STEP) && step_done),
    .angle  (pitch_turn),
    .done   (rot_done_p),
    .result (sc_p)
  );

  assign rot_done = rot_done_h && rot_done_p;

  // Exact Q60 products cos p * sin h and cos p * cos h
  ypld_serial_mul #(.A_W(CORDIC_W), .B_W(CORDIC_W)) u_mul_x (
    .clk     (clk),
    .rst     (rst),
    .start   ((state == ST_ROTATE) && rot_done),
    .a       (sc_p.cos_v),
    .b       (sc_h.sin_v),
    .done    (done_x),
    .product (prod_x)
  );

  ypld_serial_mul #(.A_W(CORDIC_W), .B_W(CORDIC_W)) u_mul_z (
    .clk     (clk),
    .rst     (rst),
    .start   ((state == ST_ROTATE) && rot_done),
    .a       (sc_p.cos_v),
    .b       (sc_h.cos_v),
    .done    (done_z),
    .product (prod_z)
  );

  assign prod_done = done_x && done_z;

  // Advance the item sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_done) begin
          state_next = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (rot_done) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        if (prod_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Round the vector components and widen the angles to their fields
  assign look_x   = dir_round(prod_x, SH_P);
  assign look_y   = dir_round({{(64 - CORDIC_W){sc_p.sin_v[CORDIC_W-1]}}, sc_p.sin_v}, SH_S);
  assign look_z   = dir_round(-prod_z, SH_P);
  assign head_ext = 32'(heading_angle);
  assign elev_ext = P_W'(elevation_angle);

  // Load the output register when it is free or being drained
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, elev_ext[ELEV_W-1:0], head_ext[HEAD_W-1:0],
                       look_z, look_y, look_x};
    end
  end

  // Checks
  `YPLD_ASSERT_NEXT(a_accept_starts_step, in_accept, state == ST_STEP,
    "accepted transaction did not start the scaling step")
  `YPLD_ASSERT_SAME(a_elev_in_range, state == ST_IDLE,
    (elevation_angle <= ELEV_MAX) && (elevation_angle >= ELEV_MIN),
    "elevation outside the pitch clamp")
  `YPLD_ASSERT_NEXT(a_load_frees_input, out_load, m_axis_tvalid && s_axis_tready,
    "result load did not present output and reopen input")

endmodule
